FILE: rtl/bilateral_gaussian_pair_potential_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the bilateral Gaussian pair potential unit
// ---------------------------------------------------------------------------
`ifndef BILATERAL_GAUSSIAN_PAIR_POTENTIAL_UNIT_DEFINES_SVH
`define BILATERAL_GAUSSIAN_PAIR_POTENTIAL_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define BGP_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BGP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bgp_pkg.sv
// ---------------------------------------------------------------------------
// bgp_pkg
// Shared types and constants for the bilateral Gaussian pair potential unit.
// ---------------------------------------------------------------------------
package bgp_pkg;

    localparam int unsigned ENERGY_W = 40;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;

    // register indexes
    localparam logic [2:0] REG_W_BIL = 3'd0;
    localparam logic [2:0] REG_W_SPA = 3'd1;
    localparam logic [2:0] REG_C_ALPHA = 3'd2;
    localparam logic [2:0] REG_C_BETA = 3'd3;
    localparam logic [2:0] REG_C_GAMMA = 3'd4;

    // datapath phase select
    typedef enum logic [2:0] {
        OP_ACC,
        OP_MUL_BETA,
        OP_MUL_ALPHA,
        OP_MUL_GAMMA,
        OP_EXP_B,
        OP_EXP_S,
        OP_WEIGHT,
        OP_FINISH
    } bgp_op_t;

    // controller to datapath command
    typedef struct packed {
        logic    load;     // capture the incoming word
        logic    run;      // do one step of op
        bgp_op_t op;
        logic    clear;    // clear energy at end of pixel
    } bgp_cmd_t;

    // 2^(-i/2^bits) in Q.16, Taylor series of exp(-z) in Q.32
    function automatic logic [16:0] frac_entry(input int unsigned i, input int unsigned bits);
        logic [63:0] f;
        logic [63:0] z;
        logic [63:0] term;
        logic signed [64:0] sum;
        logic [63:0] r;
        f = 64'(i) << (32 - bits);
        z = (f * 64'hB17217F8) >> 32;
        term = 64'h1_0000_0000;
        sum = 65'sd4294967296;
        for (int k = 1; k <= 20; k++)
        begin
            term = ((term * z) >> 32) / 64'(k);
            if (k % 2 == 1)
                sum = sum - $signed({1'b0, term});
            else
                sum = sum + $signed({1'b0, term});
        end
        if (sum < 0)
            sum = '0;
        r = (64'(sum) + 64'd32768) >> 16;
        return r[16:0];
    endfunction

endpackage

FILE: rtl/bilateral_gaussian_pair_potential_unit.sv
// Intensity channels are taken one per cycle while idle with no result pending; a last
// channel's word runs through the shared 16x32 multiplier (3+2+2 slices for arguments,
// 3+3 for exp), then the block weights, scales and saturates, and presents the word.
// No new channel is taken until the previous pixel's result word has been taken.
// Reset: asynchronous active low; weights go to 1.0, coefficients and energy to 0.
// ---------------------------------------------------------------------------
// bilateral_gaussian_pair_potential_unit
// Top level: config registers, sequencer and datapath.
// ---------------------------------------------------------------------------
module bilateral_gaussian_pair_potential_unit
    import bgp_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int EXP_TABLE_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] feature_value
    input  logic        s_tlast,   // last_channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] potential
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] w_bil_reg, w_spa_reg;
    logic [31:0] c_alpha_reg, c_beta_reg, c_gamma_reg;
    bgp_cmd_t cmd;
    logic mul_done;

    assign cfg_ready = 1'b1;

    // config register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_bil_reg <= 16'd4096;
            w_spa_reg <= 16'd4096;
            c_alpha_reg <= '0;
            c_beta_reg <= '0;
            c_gamma_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_W_BIL:   w_bil_reg <= cfg_data[15:0];
                REG_W_SPA:   w_spa_reg <= cfg_data[15:0];
                REG_C_ALPHA: c_alpha_reg <= cfg_data;
                REG_C_BETA:  c_beta_reg <= cfg_data;
                REG_C_GAMMA: c_gamma_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    bgp_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_last(s_tlast), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .mul_done(mul_done), .cmd(cmd)
    );

    bgp_datapath #(.MAX_CHANNELS(MAX_CHANNELS), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .feature_value(s_tdata),
        .w_bil(w_bil_reg), .w_spa(w_spa_reg),
        .c_alpha(c_alpha_reg), .c_beta(c_beta_reg), .c_gamma(c_gamma_reg),
        .mul_done(mul_done), .potential(m_tdata)
    );

endmodule

FILE: rtl/bgp_ctrl.sv
// ---------------------------------------------------------------------------
// bgp_ctrl
// Sequencer: accepts channel words, steps the datapath through a pixel.
// ---------------------------------------------------------------------------
module bgp_ctrl
    import bgp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_last,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    input  logic     mul_done,
    output bgp_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_BETA, S_ALPHA, S_GAMMA, S_EXPB, S_EXPS, S_WGT, S_FIN, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    // accept when idle and output slot free
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '{load: 1'b0, run: 1'b0, op: OP_ACC, clear: 1'b0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    cmd.op = OP_ACC;
                    cmd.run = !in_last;
                    if (in_last)
                        state_next = S_BETA;
                end
            end
            S_BETA:
            begin
                cmd.run = 1'b1; cmd.op = OP_MUL_BETA;
                if (mul_done) state_next = S_ALPHA;
            end
            S_ALPHA:
            begin
                cmd.run = 1'b1; cmd.op = OP_MUL_ALPHA;
                if (mul_done) state_next = S_GAMMA;
            end
            S_GAMMA:
            begin
                cmd.run = 1'b1; cmd.op = OP_MUL_GAMMA;
                if (mul_done) state_next = S_EXPB;
            end
            S_EXPB:
            begin
                cmd.run = 1'b1; cmd.op = OP_EXP_B;
                if (mul_done) state_next = S_EXPS;
            end
            S_EXPS:
            begin
                cmd.run = 1'b1; cmd.op = OP_EXP_S;
                if (mul_done) state_next = S_WGT;
            end
            S_WGT:
            begin
                cmd.run = 1'b1; cmd.op = OP_WEIGHT;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.run = 1'b1; cmd.op = OP_FINISH; cmd.clear = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: rtl/bgp_datapath.sv
// ---------------------------------------------------------------------------
// bgp_datapath
// Energy accumulator, shared 16x32 multiplier, exp table and weighting.
// ---------------------------------------------------------------------------
module bgp_datapath
    import bgp_pkg::*;
#(
    parameter int MAX_CHANNELS = 8,
    parameter int EXP_TABLE_BITS = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  bgp_cmd_t           cmd,
    input  logic signed [15:0] feature_value,
    input  logic signed [15:0] w_bil,
    input  logic signed [15:0] w_spa,
    input  logic [31:0]        c_alpha,
    input  logic [31:0]        c_beta,
    input  logic [31:0]        c_gamma,
    output logic               mul_done,
    output logic [31:0]        potential
);

    localparam int CNT_W = $clog2(MAX_CHANNELS);
    localparam int TSIZE = 1 << EXP_TABLE_BITS;
    localparam logic [ENERGY_W-1:0] EMAX = '1;

    // fraction table as constant logic
    logic [16:0] frac_rom [TSIZE];
    for (genvar g = 0; g < TSIZE; g++)
    begin : g_rom
        assign frac_rom[g] = frac_entry(g, EXP_TABLE_BITS);
    end

    logic [ENERGY_W-1:0] energy_reg, energy_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [31:0]         sq_reg;
    logic [47:0]         xb_reg, xs_reg;   // Q.16 arguments
    logic [16:0]         eb_reg, es_reg;
    logic [2:0]          part_reg;         // 16-bit slice of multiplicand
    logic [79:0]         macc_reg;         // partial product sum
    logic signed [34:0]  acc_reg;
    logic [31:0]         pot_reg;

    // square of the signed word; low 32 bits of the sign-extended product
    logic [31:0] sq_now;
    logic [40:0] sum_e;
    assign sq_now = {{16{feature_value[15]}}, feature_value}
                  * {{16{feature_value[15]}}, feature_value};
    assign sum_e = {1'b0, energy_reg} + 41'(sq_now);

    // multiplier operands per phase: 16-bit slice of a*c, up to 3 slices
    logic [47:0] mul_a;
    logic [31:0] mul_c;
    logic [2:0]  nparts;
    always_comb
    begin
        mul_a = '0; mul_c = '0; nparts = 3'd1;
        case (cmd.op)
            OP_MUL_BETA:  begin mul_a = 48'(energy_reg); mul_c = c_beta; nparts = 3'd3; end
            OP_MUL_ALPHA: begin mul_a = 48'(sq_reg); mul_c = c_alpha; nparts = 3'd2; end
            OP_MUL_GAMMA: begin mul_a = 48'(sq_reg); mul_c = c_gamma; nparts = 3'd2; end
            OP_EXP_B:     begin mul_a = xb_reg; mul_c = 32'(LOG2E_Q16); nparts = 3'd3; end
            OP_EXP_S:     begin mul_a = xs_reg; mul_c = 32'(LOG2E_Q16); nparts = 3'd3; end
            default:      ;
        endcase
    end

    logic [15:0] slice;
    logic [47:0] pp;
    logic [79:0] macc_sum;
    assign slice = mul_a[16*part_reg[1:0] +: 16];
    assign pp = 48'(slice) * 48'(mul_c);
    assign macc_sum = macc_reg + (80'(pp) << (16 * part_reg[1:0]));
    assign mul_done = (part_reg == nparts - 3'd1);

    // exp from y = x*log2e in Q.16 (macc_sum >> 16)
    logic [63:0] y;
    logic [16:0] exp_val;
    logic [47:0] x_arg;
    always_comb
    begin
        y = macc_sum[79:16];
        x_arg = (cmd.op == OP_EXP_B) ? xb_reg : xs_reg;
        if (x_arg >= (48'd64 << 16) || y[63:21] != '0)
            exp_val = '0;
        else
            exp_val = frac_rom[y[15 -: EXP_TABLE_BITS]] >> y[20:16];
    end

    // weighted sum, both products widened before multiplying
    logic signed [34:0] wsum;
    logic signed [35:0] res;
    assign wsum = 35'(w_bil) * 35'(signed'({1'b0, eb_reg}))
                + 35'(w_spa) * 35'(signed'({1'b0, es_reg}));
    assign res = 36'(acc_reg >>> 12);

    always_comb
    begin
        energy_next = energy_reg;
        count_next = count_reg;
        if (cmd.load && cmd.run && 32'(count_reg) < MAX_CHANNELS - 1)
        begin
            count_next = count_reg + 1'b1;
            energy_next = sum_e[40] ? EMAX : sum_e[ENERGY_W-1:0];
        end
        if (cmd.clear)
        begin
            energy_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_reg <= '0;
            count_reg <= '0;
            part_reg <= '0;
            macc_reg <= '0;
        end
        else
        begin
            energy_reg <= energy_next;
            count_reg <= count_next;
            if (cmd.run && cmd.op != OP_ACC && cmd.op != OP_WEIGHT && cmd.op != OP_FINISH)
            begin
                part_reg <= mul_done ? 3'd0 : part_reg + 3'd1;
                macc_reg <= mul_done ? '0 : macc_sum;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            sq_reg <= sq_now;
        if (cmd.run && mul_done)
        begin
            case (cmd.op)
                OP_MUL_BETA:  xb_reg <= macc_sum[71:24];
                OP_MUL_ALPHA: xb_reg <= xb_reg + macc_sum[71:24];
                OP_MUL_GAMMA: xs_reg <= macc_sum[71:24];
                OP_EXP_B:     eb_reg <= exp_val;
                OP_EXP_S:     es_reg <= exp_val;
                default:      ;
            endcase
        end
        if (cmd.run && cmd.op == OP_WEIGHT)
            acc_reg <= wsum;
        if (cmd.run && cmd.op == OP_FINISH)
        begin
            if (res > 36'sd2147483647)
                pot_reg <= 32'h7FFF_FFFF;
            else if (res < -36'sd2147483648)
                pot_reg <= 32'h8000_0000;
            else
                pot_reg <= res[31:0];
        end
    end

    assign potential = pot_reg;

endmodule

FILE: rtl/bgp_checker.sv
// ---------------------------------------------------------------------------
// bgp_checker
// Port-level checks on the pair potential unit.
// ---------------------------------------------------------------------------
`include "bilateral_gaussian_pair_potential_unit_defines.svh"

module bgp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a pending result holds its word
    `BGP_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")
    // a last channel cannot be followed by an immediate result
    `BGP_ASSERT_NEXT(a_no_fast, s_tvalid && s_tready && s_tlast, !m_tvalid, "result too early")
    // no input taken while a result waits
    `BGP_ASSERT_IMPL(a_block, m_tvalid, !s_tready, "input taken with result pending")

endmodule

bind bilateral_gaussian_pair_potential_unit bgp_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Bilateral Gaussian pair potential unit: streams pixel channels through the
// block under bursty input and a stalling output, predicts each pixel's
// potential in fixed point and checks every result word in order.
// ---------------------------------------------------------------------------
module testbench;
    import bgp_pkg::*;

    localparam int CHANNELS_MAX = 8;
    localparam int FRAC_BITS = 8;
    localparam int FRAC_SIZE = 1 << FRAC_BITS;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int SETTLE_CYCLES = 40;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // predictor state
    logic [15:0] w_bil, w_spa;
    logic [31:0] c_alpha, c_beta, c_gamma;
    logic [39:0] isq_sum;
    int          isq_count;
    logic [16:0] frac_lut [FRAC_SIZE];

    logic [31:0] potential_q[$];
    int          error_count;
    int          words_sent;
    int          burst_left;
    bit          gaps_on;

    bilateral_gaussian_pair_potential_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    // 2^(-i/2^bits) in Q.16 via Taylor series of exp(-z) in Q.32
    function automatic logic [16:0] pow2_frac(input int unsigned i);
        logic [63:0] f;
        logic [63:0] z;
        logic [63:0] term;
        longint      acc;
        f = 64'(i) << (32 - FRAC_BITS);
        z = (f * 64'hB17217F8) >> 32;
        term = 64'h1_0000_0000;
        acc = longint'(term);
        for (int k = 1; k <= 20; k++)
        begin
            term = ((term * z) >> 32) / 64'(k);
            if (k % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        return 17'((64'(acc) + 64'd32768) >> 16);
    endfunction

    function automatic logic [79:0] scale_q24(input logic [40:0] e, input logic [31:0] c);
        return (80'(e) * 80'(c)) >> 24;
    endfunction

    // exp(-x), x and result in Q.16
    function automatic logic [16:0] decay(input logic [79:0] x);
        logic [79:0] y;
        logic [79:0] k;
        logic [FRAC_BITS-1:0] idx;
        if (x >= (80'd64 << 16))
            return '0;
        y = (x * 80'd94548) >> 16;
        k = y >> 16;
        if (k >= 80'd32)
            return '0;
        idx = y[15 -: FRAC_BITS];
        return frac_lut[idx] >> k;
    endfunction

    // update the model with one accepted channel word
    task automatic predict_channel(input logic [15:0] v, input logic last);
        logic [39:0] sq;
        logic [79:0] xb, xs;
        logic [16:0] eb, es;
        longint      acc;
        longint      res;
        sq = 40'(longint'($signed(v)) * longint'($signed(v)));
        if (!last)
        begin
            if (isq_count < CHANNELS_MAX - 1)
            begin
                isq_count++;
                if (41'(isq_sum) + 41'(sq) > 41'(40'hFF_FFFF_FFFF))
                    isq_sum = 40'hFF_FFFF_FFFF;
                else
                    isq_sum = isq_sum + sq;
            end
            return;
        end
        xb = scale_q24(41'(isq_sum), c_beta) + scale_q24(41'(sq), c_alpha);
        xs = scale_q24(41'(sq), c_gamma);
        eb = decay(xb);
        es = decay(xs);
        acc = longint'($signed(w_bil)) * longint'(eb)
            + longint'($signed(w_spa)) * longint'(es);
        res = acc >>> 12;
        if (res > 64'sd2147483647)
            res = 64'sd2147483647;
        if (res < -64'sd2147483648)
            res = -64'sd2147483648;
        potential_q.push_back(res[31:0]);
        isq_sum = '0;
        isq_count = 0;
    endtask

    // send one channel word; called and returns at a rising edge
    task automatic push_channel(input logic [15:0] v, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
        predict_channel(v, last);
        words_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        while (!cfg_ready)
            @(negedge clk);
        @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_W_BIL:   w_bil = val[15:0];
            REG_W_SPA:   w_spa = val[15:0];
            REG_C_ALPHA: c_alpha = val;
            REG_C_BETA:  c_beta = val;
            REG_C_GAMMA: c_gamma = val;
            default: ;
        endcase
    endtask

    // wait until every result is in, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (potential_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_feature();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed(16'($urandom)) >>> $urandom_range(4, 14));
            2: return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
            default: return 16'($signed(16'($urandom)) >>> $urandom_range(8, 15));
        endcase
    endfunction

    function automatic logic [31:0] pick_coef();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom >> $urandom_range(4, 31);
        endcase
    endfunction

    task automatic random_pixel();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 10) : $urandom_range(0, 6);
        for (int i = 0; i < n; i++)
            push_channel(pick_feature(), 1'b0);
        push_channel(pick_feature(), 1'b1);
    endtask

    // ---- tests ----
    task automatic test_reset_values();
        push_channel(16'h0100, 1'b0);
        push_channel(16'h0200, 1'b1);
        push_channel(16'h7FFF, 1'b1);
        drain();
    endtask

    task automatic test_edges();
        write_reg(REG_W_BIL, 32'h0000_8000);
        write_reg(REG_W_SPA, 32'h0000_8000);
        write_reg(REG_C_ALPHA, 32'h0000_1000);
        write_reg(REG_C_BETA, 32'h0000_0800);
        write_reg(REG_C_GAMMA, 32'h0000_2000);
        // extremes of the feature value, a three-channel pixel and one-channel pixels
        push_channel(16'h8000, 1'b0);
        push_channel(16'h7FFF, 1'b0);
        push_channel(16'h0000, 1'b1);
        push_channel(16'h8000, 1'b1);
        push_channel(16'hFFFF, 1'b1);
        // more intensity channels than the block keeps
        for (int i = 0; i < 10; i++)
            push_channel(16'h0040 + 16'(i), 1'b0);
        push_channel(16'h0080, 1'b1);
        drain();
        // positive extreme weights, huge coefficients flush both terms for large features
        write_reg(REG_W_BIL, 32'h0000_7FFF);
        write_reg(REG_W_SPA, 32'h0000_7FFF);
        write_reg(REG_C_ALPHA, 32'hFFFF_FFFF);
        write_reg(REG_C_BETA, 32'hFFFF_FFFF);
        write_reg(REG_C_GAMMA, 32'hFFFF_FFFF);
        push_channel(16'h7FFF, 1'b0);
        push_channel(16'h7FFF, 1'b1);
        push_channel(16'h0001, 1'b1);
        push_channel(16'h0000, 1'b1);
        drain();
        // spare indexes leave the registers alone
        write_reg(REG_SPARE_LO, 32'h0000_0000);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        push_channel(16'h0000, 1'b1);
        drain();
    endtask

    task automatic test_random(input int target);
        int phase_end;
        phase_end = words_sent + target;
        write_reg(REG_W_BIL, ($urandom_range(0, 3) == 0) ? 32'h8000 : $urandom);
        write_reg(REG_W_SPA, ($urandom_range(0, 3) == 0) ? 32'h7FFF : $urandom);
        write_reg(REG_C_ALPHA, pick_coef());
        write_reg(REG_C_BETA, pick_coef());
        write_reg(REG_C_GAMMA, pick_coef());
        write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), $urandom);
        gaps_on = ($urandom_range(0, 3) != 0);
        while (words_sent < phase_end)
        begin
            if ($urandom_range(0, 40) == 0)
                push_channel(pick_feature(), 1'($urandom));
            else
                random_pixel();
            if ($urandom_range(0, 60) == 0)
                drain();
        end
        drain();
    endtask

    // ---- result check ----
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (potential_q.size() == 0)
            begin
                $error("unexpected result word potential=%h", m_tdata);
                error_count++;
            end
            else
            begin
                if (m_tdata !== potential_q[0])
                begin
                    $error("potential expected %h actual %h", potential_q[0], m_tdata);
                    error_count++;
                end
                void'(potential_q.pop_front());
            end
        end
    end

    // ---- output back-pressure ----
    int unsigned stall_cnt;
    logic [1:0]  stall_mode;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_cnt  <= 0;
            stall_mode <= 2'd0;
            m_tready   <= 1'b0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt[7:0] == 8'hFF)
                stall_mode <= 2'($urandom);
            case (stall_mode)
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom);
                2'd2: m_tready <= (stall_cnt[3:0] < 4'd12);
                default: m_tready <= (stall_cnt[5:0] >= 6'd40);
            endcase
        end
    end

    initial
    begin
        #20_000_000;
        $display("testbench: errors");
        $finish;
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        words_sent = 0;
        burst_left = 0;
        gaps_on = 1'b1;
        w_bil = 16'd4096;
        w_spa = 16'd4096;
        c_alpha = '0;
        c_beta = '0;
        c_gamma = '0;
        isq_sum = '0;
        isq_count = 0;
        for (int i = 0; i < FRAC_SIZE; i++)
            frac_lut[i] = pow2_frac(i);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_edges();
        for (int p = 0; p < 6; p++)
            test_random(237);

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
